FILE: sv/apq_pkg.sv
package apq_pkg;

    localparam int unsigned DEPTH  = 16;
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned DATA_W = 32;
    localparam int unsigned PRIO_W = 16;
    localparam int unsigned OP_W   = 2;
    localparam int unsigned STS_W  = 2;

    typedef logic [CNT_W-1:0] t_count;
    typedef logic [OP_W-1:0]  t_op;
    typedef logic [STS_W-1:0] t_status;

    localparam t_op OP_ENQUEUE = 2'd0;
    localparam t_op OP_DEQUEUE = 2'd1;
    localparam t_op OP_PEEK    = 2'd2;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic        [PRIO_W-1:0] prio;
    } t_entry;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic   enq;        // insert new_entry at its sorted place
        logic   deq;        // drop the head, everything moves toward the head
        t_entry new_entry;
    } t_cell_ctrl;

endpackage

FILE: sv/apq_cell.sv
module apq_cell (
    input  logic               i_clk,
    input  apq_pkg::t_cell_ctrl i_ctrl,
    input  logic               i_first,
    input  logic               i_self_occ,
    input  logic               i_left_occ,
    input  apq_pkg::t_entry    i_left,
    input  apq_pkg::t_entry    i_right,
    output apq_pkg::t_entry    o_entry
);

    apq_pkg::t_entry r_entry;
    apq_pkg::t_entry n_entry;
    logic            w_stays;
    logic            w_left_ge;

    // entries are kept sorted by priority, ties in arrival order
    assign w_stays   = i_self_occ && (r_entry.prio >= i_ctrl.new_entry.prio);
    assign w_left_ge = i_first || (i_left_occ && (i_left.prio >= i_ctrl.new_entry.prio));

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.enq && !w_stays) begin
            n_entry = w_left_ge ? i_ctrl.new_entry : i_left;
        end else if (i_ctrl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

FILE: sv/array_priority_queue_unit.sv
// array_priority_queue_unit
//
// priority queue of up to apq_pkg::DEPTH entries (data word plus priority).
// input channel: i_in_valid / o_in_stall with i_operation, i_item_data and
// i_item_priority; operation selects enqueue, dequeue or peek.
// output channel: o_out_valid / i_out_stall, one result transaction per input
// transaction carrying o_out_data, o_out_priority, o_status and o_fill_count.
// the entries sit in a row of cells kept sorted by priority (ties in arrival
// order), so the best entry is always the head cell and is read directly.
// an enqueue compares the new priority in every cell at once and the row
// opens a gap by moving one place away from the head; a dequeue moves the
// whole row one place toward the head.
// an accepted operation waits in its capture register, then executes,
// updating the cell row and the result register together; no new transaction
// is taken before it executes, but the next is taken while its result waits.
// reset (synchronous, active low) empties the queue and drops any result;
// cell contents are not cleared. a stalled result holds the result register,
// and an operation already captured waits in its register until it frees.
// error results (full on enqueue, empty on dequeue or peek) leave the
// queue untouched and report zero data and priority.
module array_priority_queue_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [apq_pkg::OP_W-1:0]             i_operation,
    input  logic signed [apq_pkg::DATA_W-1:0]    i_item_data,
    input  logic [apq_pkg::PRIO_W-1:0]           i_item_priority,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [apq_pkg::DATA_W-1:0]    o_out_data,
    output logic [apq_pkg::PRIO_W-1:0]           o_out_priority,
    output logic [apq_pkg::STS_W-1:0]            o_status,
    output logic [apq_pkg::CNT_W-1:0]            o_fill_count
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state              r_state, n_state;
    apq_pkg::t_op        r_op;
    apq_pkg::t_entry     r_item;
    apq_pkg::t_count     r_count, n_count;

    logic                r_out_valid, n_out_valid;
    apq_pkg::t_entry     r_out_entry, n_out_entry;
    apq_pkg::t_status    r_out_status, n_out_status;
    apq_pkg::t_count     r_out_count, n_out_count;

    apq_pkg::t_cell_ctrl w_ctrl;
    apq_pkg::t_entry     w_entry [apq_pkg::DEPTH];
    logic [apq_pkg::DEPTH-1:0] w_occ;

    logic w_accept;
    logic w_out_free;
    logic w_commit;
    logic w_full;
    logic w_empty;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    // captured operation executes once the result register can take it
    assign w_commit   = (r_state == S_EXEC) && w_out_free;
    assign w_full     = (r_count == apq_pkg::t_count'(apq_pkg::DEPTH));
    assign w_empty    = (r_count == '0);

    // ---------------------------------------------------------------
    // cell row
    // ---------------------------------------------------------------
    always_comb begin
        w_ctrl.new_entry = r_item;
        w_ctrl.enq       = w_commit && (r_op == apq_pkg::OP_ENQUEUE) && !w_full;
        w_ctrl.deq       = w_commit && (r_op == apq_pkg::OP_DEQUEUE) && !w_empty;
    end

    for (genvar gi = 0; gi < apq_pkg::DEPTH; gi++) begin : g_cell
        // a cell is occupied when it lies below the fill count
        assign w_occ[gi] = (apq_pkg::t_count'(gi) < r_count);

        if (gi == 0) begin : g_head
            apq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_first    (1'b1),
                .i_self_occ (w_occ[gi]),
                .i_left_occ (1'b1),
                .i_left     (w_entry[gi]),
                .i_right    (w_entry[gi+1]),
                .o_entry    (w_entry[gi])
            );
        end else if (gi == apq_pkg::DEPTH - 1) begin : g_tail
            apq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_first    (1'b0),
                .i_self_occ (w_occ[gi]),
                .i_left_occ (w_occ[gi-1]),
                .i_left     (w_entry[gi-1]),
                .i_right    (w_entry[gi]),
                .o_entry    (w_entry[gi])
            );
        end else begin : g_mid
            apq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_first    (1'b0),
                .i_self_occ (w_occ[gi]),
                .i_left_occ (w_occ[gi-1]),
                .i_left     (w_entry[gi-1]),
                .i_right    (w_entry[gi+1]),
                .o_entry    (w_entry[gi])
            );
        end
    end

    // ---------------------------------------------------------------
    // control and result
    // ---------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_out_entry  = r_out_entry;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_commit) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_entry  = '0;
                    n_out_status = apq_pkg::STATUS_OK;
                    if (r_op == apq_pkg::OP_ENQUEUE) begin
                        if (w_full) begin
                            n_out_status = apq_pkg::STATUS_FULL;
                        end else begin
                            n_count = r_count + apq_pkg::t_count'(1);
                        end
                    end else if (r_op == apq_pkg::OP_DEQUEUE || r_op == apq_pkg::OP_PEEK) begin
                        if (w_empty) begin
                            n_out_status = apq_pkg::STATUS_EMPTY;
                        end else begin
                            // head cell always holds the best entry
                            n_out_entry = w_entry[0];
                            if (r_op == apq_pkg::OP_DEQUEUE) begin
                                n_count = r_count - apq_pkg::t_count'(1);
                            end
                        end
                    end
                    n_out_count = n_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= i_operation;
            r_item.data <= i_item_data;
            r_item.prio <= i_item_priority;
        end
        r_out_entry  <= n_out_entry;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_entry.data;
    assign o_out_priority = r_out_entry.prio;
    assign o_status       = r_out_status;
    assign o_fill_count   = r_out_count;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= apq_pkg::t_count'(apq_pkg::DEPTH))
        else $error("fill count above depth");

    a_enq_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.enq |=> (r_count == $past(r_count) + apq_pkg::t_count'(1)))
        else $error("enqueue did not grow the fill count");

    a_head_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= apq_pkg::t_count'(2)) |-> (w_entry[0].prio >= w_entry[1].prio))
        else $error("head cell is not the best entry");

    a_empty_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == apq_pkg::STATUS_EMPTY) |-> (o_fill_count == '0))
        else $error("empty status with entries held");

endmodule

FILE: sim/apq_checker.sv
`timescale 1ns / 1ps

module apq_checker
    import apq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  t_op                      i_operation,
    input  logic signed [DATA_W-1:0] i_item_data,
    input  logic [PRIO_W-1:0]        i_item_priority,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic signed [DATA_W-1:0] i_out_data,
    input  logic [PRIO_W-1:0]        i_out_priority,
    input  t_status                  i_status,
    input  t_count                   i_fill_count,
    output int                       o_mismatches,
    output int                       o_pending,
    output int                       o_checked,
    output int                       o_full_seen,
    output int                       o_empty_seen
);

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [PRIO_W-1:0]        prio;
        t_status                  status;
        t_count                   fill;
    } t_outcome;

    // shadow copy of the queue, kept in arrival order
    t_entry   shadow_entries [DEPTH];
    int       shadow_fill;
    t_outcome outcome_queue [$];

    // applies one operation to the shadow queue and returns its result
    function automatic t_outcome apply_operation(t_op op, logic signed [DATA_W-1:0] data,
                                                 logic [PRIO_W-1:0] prio);
        t_outcome res;
        int       best;
        res = '0;
        res.status = STATUS_OK;
        case (op)
            OP_ENQUEUE: begin
                if (shadow_fill >= DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    shadow_entries[shadow_fill].data = data;
                    shadow_entries[shadow_fill].prio = prio;
                    shadow_fill++;
                end
            end
            OP_DEQUEUE, OP_PEEK: begin
                if (shadow_fill == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    // strict compare keeps the earliest entry on a tie
                    best = 0;
                    for (int i = 1; i < shadow_fill; i++) begin
                        if (shadow_entries[i].prio > shadow_entries[best].prio) best = i;
                    end
                    res.data = shadow_entries[best].data;
                    res.prio = shadow_entries[best].prio;
                    if (op == OP_DEQUEUE) begin
                        for (int i = best; i < shadow_fill - 1; i++) begin
                            shadow_entries[i] = shadow_entries[i + 1];
                        end
                        shadow_fill--;
                    end
                end
            end
            default: ;
        endcase
        res.fill = t_count'(shadow_fill);
        return res;
    endfunction

    task automatic report_mismatch(string why, t_outcome want, t_outcome got);
        o_mismatches++;
        if (o_mismatches <= 10) begin
            $display("mismatch %0d, %s: expected data %0d prio %0d status %0d fill %0d,",
                     o_mismatches, why, want.data, want.prio, want.status, want.fill);
            $display("    got data %0d prio %0d status %0d fill %0d at %0t",
                     got.data, got.prio, got.status, got.fill, $realtime);
        end
    endtask

    initial begin
        shadow_fill  = 0;
        o_mismatches = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_full_seen  = 0;
        o_empty_seen = 0;
    end

    always @(posedge i_clk) begin : watch
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            shadow_fill = 0;
            outcome_queue.delete();
        end else begin
            // the result leaving now belongs to an older transaction than any
            // accepted at this edge, so compare before predicting
            if (i_out_valid && !i_out_stall) begin
                got.data   = i_out_data;
                got.prio   = i_out_priority;
                got.status = i_status;
                got.fill   = i_fill_count;
                if (got.status == STATUS_FULL) o_full_seen++;
                if (got.status == STATUS_EMPTY) o_empty_seen++;
                if (outcome_queue.size() == 0) begin
                    report_mismatch("result with no transaction outstanding", '0, got);
                end else begin
                    want = outcome_queue.pop_front();
                    o_checked++;
                    if (got.data !== want.data || got.prio !== want.prio ||
                        got.status !== want.status || got.fill !== want.fill) begin
                        report_mismatch("wrong result", want, got);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                outcome_queue.push_back(apply_operation(i_operation, i_item_data,
                                                        i_item_priority));
            end
        end
        o_pending = outcome_queue.size();
    end

endmodule

FILE: sim/array_priority_queue_unit_test.sv
`timescale 1ns / 1ps

module array_priority_queue_unit_test;
    import apq_pkg::*;

    // selector value with no operation behind it
    localparam t_op OP_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fff_ffff;
    localparam logic [PRIO_W-1:0]        PRIO_MAX = 16'hffff;

    localparam int ITEM_TARGET = 1600;
    localparam int HOLD_CYCLES = 120;      // long output hold-off
    localparam int DRAIN_CYCLES = 10;      // idle wait after the last result
    localparam int TIMEOUT_NS = 2_000_000;

    typedef enum logic [1:0] {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} t_phase;
    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} t_stall;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    t_op                      operation = OP_ENQUEUE;
    logic signed [DATA_W-1:0] item_data = '0;
    logic [PRIO_W-1:0]        item_priority = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] out_data;
    logic [PRIO_W-1:0]        out_priority;
    t_status                  status;
    t_count                   fill_count;

    int mismatches;
    int pending;
    int checked;
    int full_seen;
    int empty_seen;

    // receiver control: the stimulus asks for hold-offs, the receiver serves them
    t_stall stall_mode = STALL_NONE;
    int     hold_requests = 0;
    int     hold_served = 0;
    int     hold_left = 0;
    int     tick = 0;

    int op_count [4] = '{0, 0, 0, 0};
    int counted = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    array_priority_queue_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_operation     (operation),
        .i_item_data     (item_data),
        .i_item_priority (item_priority),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_out_data      (out_data),
        .o_out_priority  (out_priority),
        .o_status        (status),
        .o_fill_count    (fill_count)
    );

    apq_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_operation     (operation),
        .i_item_data     (item_data),
        .i_item_priority (item_priority),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_data      (out_data),
        .i_out_priority  (out_priority),
        .i_status        (status),
        .i_fill_count    (fill_count),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_seen     (full_seen),
        .o_empty_seen    (empty_seen)
    );

    // offer one transaction from the falling edge and hold it until a rising
    // edge takes it; returns right at that rising edge, so a following call
    // keeps valid high without a gap
    task automatic offer_operation(t_op op, logic signed [DATA_W-1:0] data,
                                   logic [PRIO_W-1:0] prio);
        @(negedge clk);
        in_valid      = 1'b1;
        operation     = op;
        item_data     = data;
        item_priority = prio;
        do @(posedge clk); while (in_stall);
        op_count[op]++;
        if (op != OP_UNUSED) counted++;
    endtask

    // sender idles with valid low; n sets the length of the gap, zero gives none
    task automatic sender_gap(int n);
        if (n > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // sender pauses until every outstanding result has come back
    task automatic wait_for_empty_pipe();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // weighted operation choice; fill phases push toward full, drain phases
    // toward empty, and the unused selector shows up now and then
    function automatic t_op pick_operation(t_phase phase);
        int roll;
        int enq_limit;
        int deq_limit;
        roll = $urandom_range(0, 99);
        case (phase)
            PHASE_FILL:  begin enq_limit = 72; deq_limit = 87; end
            PHASE_DRAIN: begin enq_limit = 25; deq_limit = 80; end
            default:     begin enq_limit = 47; deq_limit = 77; end
        endcase
        if (roll < 3) return OP_UNUSED;
        if (roll < enq_limit) return OP_ENQUEUE;
        if (roll < deq_limit) return OP_DEQUEUE;
        return OP_PEEK;
    endfunction

    // narrow priorities give plenty of ties, the rest spans the whole range
    function automatic logic [PRIO_W-1:0] pick_priority();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return PRIO_MAX;
        if (roll < 6) return PRIO_W'($urandom_range(0, 3));
        return PRIO_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 7))
            0:       return DATA_MIN;
            1:       return DATA_MAX;
            2:       return -32'sd1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // receiver: a long hold-off when asked for one, else its own stall pattern
    always begin
        @(negedge clk);
        tick++;
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left--;
        end else if (hold_served < hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            out_stall = 1'b1;
        end else begin
            case (stall_mode)
                STALL_LIGHT:   out_stall = ($urandom_range(0, 3) == 0);
                STALL_HEAVY:   out_stall = ($urandom_range(0, 3) != 0);
                STALL_PATTERN: out_stall = ((tick % 7) >= 4);
                default:       out_stall = 1'b0;
            endcase
        end
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("array_priority_queue_unit_test failed");
        $finish;
    end

    initial begin
        t_phase phase;
        int     phase_len;
        int     burst_left;
        int     phase_no;
        bit     use_gaps;
        bit     hold_phase;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty errors, unused selector, highest priority found,
        // ties going to the earliest entry, extreme data and priorities
        offer_operation(OP_PEEK, DATA_MAX, PRIO_MAX);
        offer_operation(OP_DEQUEUE, DATA_MIN, PRIO_MAX);
        offer_operation(OP_UNUSED, -32'sd1, PRIO_MAX);
        offer_operation(OP_ENQUEUE, DATA_MIN, '0);
        offer_operation(OP_PEEK, '0, '0);
        offer_operation(OP_ENQUEUE, DATA_MAX, '0);
        offer_operation(OP_DEQUEUE, '0, '0);
        offer_operation(OP_ENQUEUE, -32'sd1, PRIO_MAX);
        offer_operation(OP_ENQUEUE, '0, PRIO_MAX);
        offer_operation(OP_ENQUEUE, 32'sd5, 16'd1);
        offer_operation(OP_PEEK, '0, '0);
        offer_operation(OP_DEQUEUE, '0, '0);
        offer_operation(OP_DEQUEUE, '0, '0);
        offer_operation(OP_UNUSED, DATA_MIN, 16'h8000);
        offer_operation(OP_DEQUEUE, '0, '0);
        offer_operation(OP_DEQUEUE, '0, '0);
        offer_operation(OP_DEQUEUE, '0, '0);
        offer_operation(OP_PEEK, '0, '0);

        // pressure: hold the output off while enqueues keep coming, so the
        // block backs up and stalls; once released the queue runs into full
        offer_operation(OP_ENQUEUE, pick_data(), pick_priority());
        hold_requests++;
        repeat (23) offer_operation(OP_ENQUEUE, pick_data(), pick_priority());
        stall_mode = STALL_LIGHT;
        wait_for_empty_pipe();

        phase_no = 0;
        while (counted < ITEM_TARGET) begin
            phase_no++;
            case ($urandom_range(0, 2))
                0:       phase = PHASE_FILL;
                1:       phase = PHASE_DRAIN;
                default: phase = PHASE_MIXED;
            endcase
            phase_len  = $urandom_range(30, 90);
            use_gaps   = ($urandom_range(0, 3) != 0);
            hold_phase = ($urandom_range(0, 5) == 0);
            burst_left = $urandom_range(1, 12);
            for (int k = 0; k < phase_len; k++) begin
                offer_operation(pick_operation(phase), pick_data(), pick_priority());
                if (k == 0 && hold_phase) hold_requests++;
                burst_left--;
                if (burst_left == 0) begin
                    if (use_gaps) sender_gap($urandom_range(0, 6));
                    burst_left = $urandom_range(1, 12);
                end
            end
            // next receiver behavior, chosen once the phase's last transaction is taken
            case ($urandom_range(0, 3))
                0:       stall_mode = STALL_NONE;
                1:       stall_mode = STALL_LIGHT;
                2:       stall_mode = STALL_HEAVY;
                default: stall_mode = STALL_PATTERN;
            endcase
            if (phase_no % 4 == 0) wait_for_empty_pipe();
        end
        stall_mode = STALL_NONE;

        wait_for_empty_pipe();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d enqueue, %0d dequeue, %0d peek and %0d unused-selector transactions",
                 op_count[OP_ENQUEUE], op_count[OP_DEQUEUE], op_count[OP_PEEK],
                 op_count[OP_UNUSED]);
        $display("checked %0d results: %0d full and %0d empty reports, %0d long output holds",
                 checked, full_seen, empty_seen, hold_requests);
        if (mismatches == 0) begin
            $display("array_priority_queue_unit_test passed");
        end else begin
            $display("array_priority_queue_unit_test failed");
        end
        $finish;
    end

endmodule
